// File: hdl/rsmm_pkg.sv
// Package for the row-sorted matrix median block.
// Holds register index codes, fixed widths and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsmm_pkg;

	// register field width and derived count width (rows*cols fits in twice that)
	localparam int REG_W = 7;
	localparam int TOT_W = 2 * REG_W;
	localparam int ELEM_W = 32;
	localparam int VAL_W = ELEM_W + 1;

	// configuration register indexes
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_RD,
		ST_INIT_CMP,
		ST_MID,
		ST_PROBE,
		ST_CMP,
		ST_EVAL
	} state_t;

endpackage
`default_nettype wire

// File: hdl/row_sorted_matrix_median.sv
// Row-sorted matrix median: load a word per cycle while idle, then binary search on value.
// After the final word, a range scan reads the first and last word of each row; then up to
// 33 candidates are tried, each by a halving search of every row with at most
// ceil(log2(cols+1)) probes per row; each step waits on one read.
// The result strobe lasts one cycle and cannot be held off. Reset clears the sequencer,
// load count and registers (rows and cols to 1); the element store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module row_sorted_matrix_median #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [31:0]          element_value,
	output logic                             busy,
	output logic                             done,
	output logic signed [31:0]               median_value,
	input  wire logic                        cfg_wr_en,
	input  wire logic                        cfg_index,
	input  wire logic [rsmm_pkg::REG_W-1:0]  cfg_data
);
	import rsmm_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;

	logic [REG_W-1:0] row_count_q, col_count_q;
	logic [REG_W-1:0] rows_eff, cols_eff;
	logic [TOT_W-1:0] total, need;
	logic [TOT_W-1:0] load_cnt_q, load_next;
	logic             accept, trigger;

	logic signed [VAL_W-1:0] low_q, high_q, mid_q, mid_d, rd_val, sat_src;
	logic signed [VAL_W:0]   diff;
	logic [TOT_W-1:0]        rank_q, base_q;
	logic [REG_W-1:0]        row_q, first_q, span_q, half, probe;
	logic                    tail_sel_q, last_row;
	logic                    done_q;
	logic signed [31:0]      median_q;

	logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
	logic                ram_wr_en;
	logic [ELEM_W-1:0]   ram_rd_data;
	logic [TOT_W-1:0]    rd_index;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= REG_W'(1);
			col_count_q <= REG_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = REG_W'(1);
		end else if (32'(row_count_q) > MAX_ROWS) begin
			rows_eff = REG_W'(MAX_ROWS);
		end else begin
			rows_eff = row_count_q;
		end
		if (col_count_q == '0) begin
			cols_eff = REG_W'(1);
		end else if (32'(col_count_q) > MAX_COLS) begin
			cols_eff = REG_W'(MAX_COLS);
		end else begin
			cols_eff = col_count_q;
		end
	end

	assign total     = TOT_W'(rows_eff) * TOT_W'(cols_eff);
	assign need      = TOT_W'((total + TOT_W'(1)) >> 1);
	assign load_next = load_cnt_q + TOT_W'(1);
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign trigger   = accept && (load_next >= total);

	// element store
	assign ram_wr_en   = accept && (32'(load_cnt_q) < DEPTH);
	assign ram_wr_addr = AW'(load_cnt_q);
	assign ram_rd_addr = AW'(rd_index);

	rsmm_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (element_value),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign rd_val   = {ram_rd_data[ELEM_W-1], ram_rd_data};
	assign half     = span_q >> 1;
	assign probe    = first_q + half;
	assign last_row = (row_q == rows_eff - REG_W'(1));

	// midpoint: difference is never negative while low <= high
	assign diff    = {high_q[VAL_W-1], high_q} - {low_q[VAL_W-1], low_q};
	assign mid_d   = low_q + VAL_W'(diff >> 1);
	assign sat_src = low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_index = base_q;
		unique case (state_q)
			ST_IDLE: begin
				if (trigger) state_d = ST_INIT_RD;
			end
			ST_INIT_RD: begin
				rd_index = tail_sel_q ? base_q + TOT_W'(cols_eff) - TOT_W'(1) : base_q;
				state_d = ST_INIT_CMP;
			end
			ST_INIT_CMP: begin
				if (tail_sel_q && last_row) begin
					state_d = ST_MID;
				end else begin
					state_d = ST_INIT_RD;
				end
			end
			ST_MID: begin
				state_d = (low_q <= high_q) ? ST_PROBE : ST_IDLE;
			end
			ST_PROBE: begin
				rd_index = base_q + TOT_W'(probe);
				if (span_q != '0) begin
					state_d = ST_CMP;
				end else if (last_row) begin
					state_d = ST_EVAL;
				end
			end
			ST_CMP: state_d = ST_PROBE;
			ST_EVAL: state_d = ST_MID;
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			rank_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == ST_IDLE && accept) begin
				load_cnt_q <= trigger ? '0 : load_next;
			end
			case (state_q)
				ST_MID: begin
					if (low_q <= high_q) begin
						rank_q <= '0;
					end else begin
						done_q <= 1'b1;
					end
				end
				ST_PROBE: begin
					if (span_q == '0) rank_q <= rank_q + TOT_W'(first_q);
				end
				default: ;
			endcase
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (trigger) begin
					low_q      <= '0;
					high_q     <= '0;
					row_q      <= '0;
					base_q     <= '0;
					tail_sel_q <= 1'b0;
				end
			end
			ST_INIT_CMP: begin
				if (!tail_sel_q) begin
					if (rd_val < low_q) low_q <= rd_val;
					tail_sel_q <= 1'b1;
				end else begin
					if (rd_val > high_q) high_q <= rd_val;
					tail_sel_q <= 1'b0;
					row_q      <= row_q + REG_W'(1);
					base_q     <= base_q + TOT_W'(cols_eff);
				end
			end
			ST_MID: begin
				if (low_q <= high_q) begin
					mid_q   <= mid_d;
					row_q   <= '0;
					base_q  <= '0;
					first_q <= '0;
					span_q  <= cols_eff;
				end else if (!sat_src[VAL_W-1] && sat_src[VAL_W-2]) begin
					median_q <= 32'sh7fffffff;
				end else begin
					median_q <= sat_src[31:0];
				end
			end
			ST_PROBE: begin
				// row finished: advance to the next row
				if (span_q == '0 && !last_row) begin
					row_q   <= row_q + REG_W'(1);
					base_q  <= base_q + TOT_W'(cols_eff);
					first_q <= '0;
					span_q  <= cols_eff;
				end
			end
			ST_CMP: begin
				if (rd_val <= mid_q) begin
					first_q <= probe + REG_W'(1);
					span_q  <= span_q - half - REG_W'(1);
				end else begin
					span_q <= half;
				end
			end
			ST_EVAL: begin
				if (rank_q < need) begin
					low_q <= mid_q + VAL_W'(1);
				end else begin
					high_q <= mid_q - VAL_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign median_value = median_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while still searching");
	a_trigger_busy: assert property (@(posedge clk) disable iff (!arst_n)
		trigger |=> busy) else $error("final word did not start the search");
	a_span_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (TOT_W'(first_q) + TOT_W'(span_q) <= TOT_W'(cols_eff)))
		else $error("row search span past end of row");
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (rank_q <= total)) else $error("rank above element count");

endmodule
`default_nettype wire

// File: hdl/rsmm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used as the element store of the median block; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rsmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: tb/rsmm_median_checker.sv
// Checker for the row-sorted matrix median block: mirrors register writes and
// loaded words, predicts each median and compares it with the strobed result.
// Depends on rsmm_pkg for widths and register index codes.
`timescale 1ns / 1ps
module rsmm_median_checker #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic                               busy,
	input  wire logic signed [rsmm_pkg::ELEM_W-1:0] element_value,
	input  wire logic                               done,
	input  wire logic signed [rsmm_pkg::ELEM_W-1:0] median_value,
	input  wire logic                               cfg_wr_en,
	input  wire logic                               cfg_index,
	input  wire logic [rsmm_pkg::REG_W-1:0]         cfg_data,
	output int                                      fail_count,
	output int                                      pending_count
);
	import rsmm_pkg::*;

	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

	logic signed [ELEM_W-1:0] matrix_copy [STORE_DEPTH];
	logic signed [ELEM_W-1:0] median_queue [$];
	logic [REG_W-1:0] row_reg;
	logic [REG_W-1:0] col_reg;
	int unsigned words_loaded;
	int errors = 0;

	function automatic int unsigned clamp_dim(input logic [REG_W-1:0] raw,
			input int unsigned limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return 32'(raw);
	endfunction

	// halving search: how many words of the row at base are <= cand
	function automatic int unsigned row_le_count(input int unsigned base,
			input int unsigned cols, input logic signed [VAL_W-1:0] cand);
		int unsigned first;
		int unsigned span;
		int unsigned half;
		first = 0;
		span = cols;
		while (span > 0) begin
			half = span / 2;
			if (matrix_copy[base + first + half] <= cand) begin
				first = first + half + 1;
				span = span - half - 1;
			end else begin
				span = half;
			end
		end
		return first;
	endfunction

	function automatic logic signed [ELEM_W-1:0] predict_median(input int unsigned rows,
			input int unsigned cols);
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		logic signed [VAL_W-1:0] mid;
		logic signed [VAL_W-1:0] head;
		logic signed [VAL_W-1:0] tail;
		int unsigned need;
		int unsigned rank;
		lo = '0;
		hi = '0;
		need = (rows * cols + 1) / 2;
		for (int unsigned r = 0; r < rows; r++) begin
			head = VAL_W'(matrix_copy[r * cols]);
			tail = VAL_W'(matrix_copy[r * cols + cols - 1]);
			if (head < lo)
				lo = head;
			if (tail > hi)
				hi = tail;
		end
		while (lo <= hi) begin
			mid = lo + ((hi - lo) >>> 1);
			rank = 0;
			for (int unsigned r = 0; r < rows; r++)
				rank += row_le_count(r * cols, cols, mid);
			if (rank < need)
				lo = mid + VAL_W'(1);
			else
				hi = mid - VAL_W'(1);
		end
		// saturate a search that ran past the top of the signed range
		if (lo > 33'sd2147483647)
			return 32'sh7fffffff;
		return lo[ELEM_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int unsigned rows_now;
		int unsigned cols_now;
		logic signed [ELEM_W-1:0] expected;
		if (!arst_n) begin
			row_reg = REG_W'(1);
			col_reg = REG_W'(1);
			words_loaded = 0;
			median_queue.delete();
			pending_count <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_ROW_COUNT)
					row_reg = cfg_data;
				else if (cfg_index == REG_COL_COUNT)
					col_reg = cfg_data;
			end
			if (done) begin
				if (median_queue.size() == 0) begin
					$display("%0t: unexpected median %0d", $time, median_value);
					errors++;
				end else begin
					expected = median_queue.pop_front();
					if (median_value !== expected) begin
						$display("%0t: median mismatch, expected %0d, got %0d",
							$time, expected, median_value);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				// dimensions are taken at each word, so mid-load changes apply at once
				rows_now = clamp_dim(row_reg, MAX_ROWS);
				cols_now = clamp_dim(col_reg, MAX_COLS);
				matrix_copy[words_loaded] = element_value;
				words_loaded++;
				if (words_loaded >= rows_now * cols_now) begin
					words_loaded = 0;
					expected = predict_median(rows_now, cols_now);
					median_queue.insert(median_queue.size(), expected);
				end
			end
			pending_count <= median_queue.size();
			fail_count <= errors;
		end
	end

endmodule

// File: tb/tb_row_sorted_matrix_median.sv
// Testbench top for row_sorted_matrix_median: drives matrix words and register
// writes with random gaps; rsmm_median_checker does prediction and comparison.
// Depends on rsmm_pkg, row_sorted_matrix_median and rsmm_median_checker.
`timescale 1ns / 1ps
module tb_row_sorted_matrix_median;
	import rsmm_pkg::*;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int WORD_TARGET = 1850;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic start;
	logic signed [ELEM_W-1:0] element_value;
	logic busy;
	logic done;
	logic signed [ELEM_W-1:0] median_value;
	logic cfg_wr_en;
	logic cfg_index;
	logic [REG_W-1:0] cfg_data;
	int fail_count;
	int pending_count;

	int words_sent = 0;
	longint cycle_count = 0;
	bit no_gaps = 0;
	logic signed [ELEM_W-1:0] row_buf [MAX_COLS];

	row_sorted_matrix_median #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.element_value(element_value),
		.busy(busy),
		.done(done),
		.median_value(median_value),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rsmm_median_checker #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) median_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.element_value(element_value),
		.done(done),
		.median_value(median_value),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int gap_cycles();
		int pick;
		if (no_gaps)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	function automatic logic signed [ELEM_W-1:0] pick_value(input int style);
		case (style)
			0: return $urandom();
			1: return $signed($urandom_range(0, 16)) - 8;
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'sh80000000;
					1: return 32'sh7fffffff;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	// hold start high across back-to-back words; lower it only for a gap
	task automatic send_word(input logic signed [ELEM_W-1:0] value);
		int gap;
		gap = gap_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		element_value <= value;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	// wait until every expected median is out and the block is idle
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_count != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_dims(input int unsigned rows_raw, input int unsigned cols_raw);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ROW_COUNT;
		cfg_data <= rows_raw[REG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_COL_COUNT;
		cfg_data <= cols_raw[REG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_matrix(input int unsigned rows, input int unsigned cols,
			input int unsigned stop_after, input bit sorted_rows, input int style);
		int unsigned sent;
		int unsigned k;
		logic signed [ELEM_W-1:0] key;
		sent = 0;
		for (int unsigned r = 0; r < rows && sent < stop_after; r++) begin
			for (int unsigned c = 0; c < cols; c++)
				row_buf[c] = pick_value(style);
			if (sorted_rows) begin
				for (int unsigned c = 1; c < cols; c++) begin
					key = row_buf[c];
					k = c;
					while (k > 0 && row_buf[k-1] > key) begin
						row_buf[k] = row_buf[k-1];
						k--;
					end
					row_buf[k] = key;
				end
			end
			for (int unsigned c = 0; c < cols && sent < stop_after; c++) begin
				send_word(row_buf[c]);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		int unsigned rows_raw;
		int unsigned cols_raw;
		int unsigned rows_eff;
		int unsigned cols_eff;
		int unsigned mats;
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		element_value = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ROW_COUNT;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset dimensions are 1x1: every word is its own median
		send_word(32'sh80000000);
		send_word(32'sh7fffffff);
		send_word(0);
		send_word(-1);
		drain();
		// zero in both registers reads as one
		set_dims(0, 0);
		send_word(5);
		drain();
		set_dims(2, 3);
		send_word(32'sh80000000);
		send_word(0);
		send_word(32'sh7fffffff);
		send_word(-5);
		send_word(7);
		send_word(32'sh7fffffff);
		drain();
		// unsorted rows
		set_dims(1, 3);
		send_word(9);
		send_word(-4);
		send_word(2);
		send_word(32'sh7fffffff);
		send_word(32'sh80000000);
		send_word(32'sh7fffffff);
		drain();
		// shrink the matrix below the words already loaded
		set_dims(2, 2);
		send_word(10);
		send_word(20);
		send_word(30);
		drain();
		set_dims(2, 1);
		send_word(40);
		drain();
		// grow the matrix mid-load
		set_dims(1, 2);
		send_word(-3);
		drain();
		set_dims(1, 3);
		send_word(-9);
		send_word(6);
		drain();

		while (words_sent < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				rows_raw = $urandom_range(1, 6);
				cols_raw = $urandom_range(1, 8);
			end else if (pick < 80) begin
				case ($urandom_range(0, 3))
					0: rows_raw = 0;
					1: rows_raw = 64;
					2: rows_raw = $urandom_range(65, 126);
					default: rows_raw = 127;
				endcase
				cols_raw = $urandom_range(0, 3);
				if ($urandom_range(0, 1)) begin
					cols_raw = rows_raw;
					rows_raw = $urandom_range(0, 3);
				end
			end else if (pick < 90) begin
				rows_raw = $urandom_range(60, 64);
				cols_raw = $urandom_range(1, 3);
			end else begin
				rows_raw = $urandom_range(1, 3);
				cols_raw = $urandom_range(60, 64);
			end
			drain();
			set_dims(rows_raw, cols_raw);
			rows_eff = clamp_dim(rows_raw, MAX_ROWS);
			cols_eff = clamp_dim(cols_raw, MAX_COLS);
			no_gaps = ($urandom_range(0, 4) == 0);
			mats = (rows_eff * cols_eff > 32) ? 1 : $urandom_range(1, 4);
			for (int unsigned m = 0; m < mats; m++)
				send_matrix(rows_eff, cols_eff, rows_eff * cols_eff,
					($urandom_range(0, 99) < 85), $urandom_range(0, 3));
			// leave a partial load so the next register write lands mid-load
			if (rows_eff * cols_eff > 1 && $urandom_range(0, 7) == 0)
				send_matrix(rows_eff, cols_eff, $urandom_range(1, rows_eff * cols_eff - 1),
					1'b1, $urandom_range(0, 3));
		end
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
hdl/rsmm_pkg.sv
hdl/rsmm_ram.sv
hdl/row_sorted_matrix_median.sv
tb/rsmm_median_checker.sv
tb/tb_row_sorted_matrix_median.sv
